// ----- src/cmg_pkg.sv -----
`default_nettype none
package cmg_pkg;

    // Widest vertex index carried between the front and back parts.
    localparam int IDX_W = 21;
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_W = 184;
    localparam int TUSER_W = 2;
    localparam int TRI_W = 51;

    // Reciprocals of the Taylor term divisors, scaled by 2^RECIP_SHIFT and rounded up.
    // With terms below 2^33 the scaled product floors to the exact quotient.
    localparam int RECIP_SHIFT = 48;
    localparam logic [63:0] RECIP_6   = ((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6;
    localparam logic [63:0] RECIP_20  = ((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20;
    localparam logic [63:0] RECIP_42  = ((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42;
    localparam logic [63:0] RECIP_72  = ((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72;
    localparam logic [63:0] RECIP_110 = ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110;
    localparam logic [63:0] RECIP_156 = ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156;
    localparam logic [63:0] RECIP_210 = ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210;

    typedef enum logic [2:0] {
        REG_RADIUS          = 3'd0,
        REG_HEIGHT          = 3'd1,
        REG_BASE_SEGMENTS   = 3'd2,
        REG_HEIGHT_SEGMENTS = 3'd3,
        REG_WITH_CAPS       = 3'd4,
        REG_U_TILING        = 3'd5,
        REG_V_TILING        = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        PART_SIDE = 4'b0001,
        PART_LOW  = 4'b0010,
        PART_HIGH = 4'b0100,
        PART_DONE = 4'b1000
    } part_t;

    // One vertex to be built by the back part.
    typedef struct packed {
        part_t              part;
        logic               centre;
        logic               jlast;
        logic               ilast;
        logic               mesh_last;
        logic [7:0]         j;
        logic [7:0]         i;
        logic [7:0]         bseg;
        logic [IDX_W-1:0]   o;
        logic [IDX_W-1:0]   cc;
        logic [15:0]        angle_step;
        logic [15:0]        u_step;
        logic [15:0]        v_step;
        logic [15:0]        h_step;
    } job_t;

    typedef struct packed {
        logic [15:0] radius;
        logic [15:0] height;
        logic [15:0] u_tiling;
        logic [15:0] v_tiling;
    } geom_cfg_t;

    function automatic logic [63:0] term_recip(input int n);
        logic [63:0] r;
        case (n)
            1: r = RECIP_6;
            2: r = RECIP_20;
            3: r = RECIP_42;
            4: r = RECIP_72;
            5: r = RECIP_110;
            6: r = RECIP_156;
            7: r = RECIP_210;
            default: r = 64'd1 << RECIP_SHIFT;
        endcase
        return r;
    endfunction

    // Quarter-wave entry in Q1.14 from an angle in Q30, by Taylor series.
    function automatic logic [14:0] sine_q14(input logic [63:0] x);
        logic [63:0] term;
        logic [127:0] scaled;
        logic signed [64:0] sum;
        term = x;
        sum = $signed({1'b0, x});
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x) >> 30) * x >> 30;
            scaled = 128'(term) * 128'(term_recip(n));
            term = scaled[RECIP_SHIFT+63:RECIP_SHIFT];
            if ((n & 1) == 1)
                sum = sum - $signed({1'b0, term});
            else
                sum = sum + $signed({1'b0, term});
        end
        if (sum < 0)
            sum = '0;
        sum = (sum + 65'sd32768) >>> 16;
        if (sum > 65'sd16384)
            sum = 65'sd16384;
        return sum[14:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/cmg_div.sv -----
`default_nettype none
module cmg_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [cmg_pkg::DIVIDEND_W-1:0]     dividend,
    input  wire logic [cmg_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                    done,
    output logic [cmg_pkg::DIVIDEND_W-1:0]          quotient
);
    import cmg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIVIDEND_W-1:0]  quo_reg, quo_next;
    logic [DIVISOR_W-1:0]   dsr_reg, dsr_next;
    logic                   done_reg, done_next;
    logic [DIVISOR_W:0]     rem_sh;
    logic                   ge;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge = rem_sh >= {1'b0, dsr_reg};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? DIVISOR_W'(rem_sh - {1'b0, dsr_reg}) : DIVISOR_W'(rem_sh);
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/cmg_queue.sv -----
`default_nettype none
module cmg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire cmg_pkg::job_t  push_job,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output cmg_pkg::job_t       pop_job
);
    import cmg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic               do_push, do_pop;

    always_comb
    begin
        push_ready = cnt_reg != (PTR_W + 1)'(QUEUE_DEPTH);
        pop_valid = cnt_reg != '0;
        do_push = push_valid && push_ready;
        do_pop = pop_valid && pop_ready;
        wr_next = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
        pop_job = mem[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_reg] <= push_job;
    end

endmodule
`default_nettype wire

// ----- src/cmg_front.sv -----
`default_nettype none
module cmg_front #(
    parameter int MAX_SEGMENTS = 255,
    parameter int INDEX_BITS = 17
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           restart,
    input  wire logic [7:0]     base_segments,
    input  wire logic [7:0]     height_segments,
    input  wire logic           with_caps,
    input  wire logic [15:0]    height,
    input  wire logic [15:0]    u_tiling,
    input  wire logic [15:0]    v_tiling,
    output logic                push_valid,
    input  wire logic           push_ready,
    output cmg_pkg::job_t       push_job
);
    import cmg_pkg::*;

    typedef enum logic [1:0] {
        F_RUN = 2'b01,
        F_DIV = 2'b10
    } fmode_t;

    fmode_t                 mode_reg, mode_next;
    part_t                  part_reg, part_next;
    logic [7:0]             ring_reg, ring_next;
    logic [8:0]             column_reg, column_next;
    logic [INDEX_BITS-1:0]  vcount_reg, vcount_next;
    logic [INDEX_BITS-1:0]  centre_reg, centre_next;
    logic [1:0]             sel_reg, sel_next;
    logic [15:0]            astep_reg, astep_next;
    logic [15:0]            ustep_reg, ustep_next;
    logic [15:0]            vstep_reg, vstep_next;
    logic [15:0]            hstep_reg, hstep_next;

    logic [7:0]             b_eff, h_eff;
    logic [8:0]             b9, col_m1, j9;
    logic                   side, centre, jlast, ilast, adv, go;
    logic                   div_start, div_done;
    logic [1:0]             op_sel;
    logic [DIVIDEND_W-1:0]  div_a, div_q;
    logic [DIVISOR_W-1:0]   div_b;

    cmg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        // Segment counts of zero act as one, counts above the limit are clipped.
        if (base_segments == 8'd0)
            b_eff = 8'd1;
        else if (base_segments > 8'(MAX_SEGMENTS))
            b_eff = 8'(MAX_SEGMENTS);
        else
            b_eff = base_segments;
        if (height_segments == 8'd0)
            h_eff = 8'd1;
        else if (height_segments > 8'(MAX_SEGMENTS))
            h_eff = 8'(MAX_SEGMENTS);
        else
            h_eff = height_segments;

        b9 = {1'b0, b_eff};
        col_m1 = column_reg - 9'd1;
        side = part_reg == PART_SIDE;
        centre = !side && column_reg == 9'd0;
        if (side)
            j9 = (column_reg < b9) ? column_reg : b9;
        else if (centre)
            j9 = 9'd0;
        else
            j9 = (col_m1 < b9) ? col_m1 : b9;
        jlast = j9 >= b9;
        ilast = side && ring_reg >= h_eff;

        in_ready = mode_reg == F_RUN && push_ready;
        adv = in_valid && in_ready && !restart;
        go = in_valid && in_ready && restart;
        push_valid = adv && part_reg != PART_DONE;

        push_job.part = part_reg;
        push_job.centre = centre;
        push_job.jlast = jlast;
        push_job.ilast = ilast;
        push_job.mesh_last = (side && jlast && ilast && !with_caps)
                             || (part_reg == PART_HIGH && !centre && jlast);
        push_job.j = j9[7:0];
        push_job.i = side ? ((ring_reg < h_eff) ? ring_reg : h_eff) : 8'd0;
        push_job.bseg = b_eff;
        push_job.o = IDX_W'(vcount_reg);
        push_job.cc = IDX_W'(centre_reg);
        push_job.angle_step = astep_reg;
        push_job.u_step = ustep_reg;
        push_job.v_step = vstep_reg;
        push_job.h_step = hstep_reg;

        // Restart runs the four step divisions in turn on one divider.
        op_sel = go ? 2'd0 : sel_reg + 2'd1;
        div_start = go || (mode_reg == F_DIV && div_done && sel_reg != 2'd3);
        case (op_sel)
            2'd0: div_a = DIVIDEND_W'(17'h10000 + {10'd0, b_eff[7:1]});
            2'd1: div_a = DIVIDEND_W'(u_tiling);
            2'd2: div_a = DIVIDEND_W'(v_tiling);
            2'd3: div_a = DIVIDEND_W'(height);
            default: div_a = '0;
        endcase
        div_b = op_sel[1] ? h_eff : b_eff;

        mode_next = mode_reg;
        part_next = part_reg;
        ring_next = ring_reg;
        column_next = column_reg;
        vcount_next = vcount_reg;
        centre_next = centre_reg;
        sel_next = sel_reg;
        astep_next = astep_reg;
        ustep_next = ustep_reg;
        vstep_next = vstep_reg;
        hstep_next = hstep_reg;

        if (mode_reg == F_DIV && div_done)
        begin
            case (sel_reg)
                2'd0: astep_next = div_q[15:0];
                2'd1: ustep_next = div_q[15:0];
                2'd2: vstep_next = div_q[15:0];
                2'd3: hstep_next = div_q[15:0];
                default: astep_next = astep_reg;
            endcase
            if (sel_reg == 2'd3)
                mode_next = F_RUN;
            else
                sel_next = sel_reg + 2'd1;
        end

        if (go)
        begin
            mode_next = F_DIV;
            sel_next = 2'd0;
            part_next = PART_SIDE;
            ring_next = '0;
            column_next = '0;
            vcount_next = '0;
            centre_next = '0;
        end
        else if (push_valid)
        begin
            vcount_next = vcount_reg + 1'b1;
            case (part_reg)
                PART_SIDE:
                begin
                    if (jlast)
                    begin
                        column_next = '0;
                        if (ilast)
                            part_next = with_caps ? PART_LOW : PART_DONE;
                        else
                            ring_next = ring_reg + 8'd1;
                    end
                    else
                        column_next = column_reg + 9'd1;
                end
                PART_LOW:
                begin
                    if (centre)
                    begin
                        centre_next = vcount_reg;
                        column_next = 9'd1;
                    end
                    else if (jlast)
                    begin
                        part_next = PART_HIGH;
                        column_next = '0;
                    end
                    else
                        column_next = column_reg + 9'd1;
                end
                PART_HIGH:
                begin
                    if (centre)
                    begin
                        centre_next = vcount_reg;
                        column_next = 9'd1;
                    end
                    else if (jlast)
                        part_next = PART_DONE;
                    else
                        column_next = column_reg + 9'd1;
                end
                default: part_next = part_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= F_RUN;
            part_reg <= PART_DONE;
            ring_reg <= '0;
            column_reg <= '0;
            vcount_reg <= '0;
            centre_reg <= '0;
            sel_reg <= '0;
            astep_reg <= '0;
            ustep_reg <= '0;
            vstep_reg <= '0;
            hstep_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            part_reg <= part_next;
            ring_reg <= ring_next;
            column_reg <= column_next;
            vcount_reg <= vcount_next;
            centre_reg <= centre_next;
            sel_reg <= sel_next;
            astep_reg <= astep_next;
            ustep_reg <= ustep_next;
            vstep_reg <= vstep_next;
            hstep_reg <= hstep_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/cmg_back.sv -----
`default_nettype none
module cmg_back #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int INDEX_BITS = 17
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_valid,
    output logic                                job_ready,
    input  wire cmg_pkg::job_t                  job,
    input  wire cmg_pkg::geom_cfg_t             geom,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cmg_pkg::TDATA_W-1:0]         m_tdata,
    output logic [cmg_pkg::TUSER_W-1:0]         m_tuser,
    output logic                                m_tlast
);
    import cmg_pkg::*;

    localparam int D = SINE_TABLE_DEPTH;
    localparam int IW = $clog2(D + 1);
    localparam int PW = 14 + IW + 1;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_PHASE = 5'b00010,
        B_TRIG  = 5'b00100,
        B_POS   = 5'b01000,
        B_EMIT  = 5'b10000
    } bstate_t;

    logic [14:0] rom [D+1];

    for (genvar g = 0; g <= D; g++)
    begin : g_rom
        localparam logic [63:0] X = (64'(g) * 64'd1686629713) / SINE_TABLE_DEPTH;
        assign rom[g] = sine_q14(X);
    end

    function automatic logic signed [15:0] sin_at(input logic [15:0] ph);
        logic [PW-1:0]  t;
        logic [IW-1:0]  idx;
        logic [14:0]    v;
        t = PW'(ph[13:0]) * PW'(D) + PW'(8192);
        idx = (t[PW-1:14] > (PW - 14)'(D)) ? IW'(D) : IW'(t[PW-1:14]);
        v = ph[14] ? rom[IW'(D) - idx] : rom[idx];
        return ph[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    bstate_t                state_reg, state_next;
    job_t                   job_reg;
    logic [23:0]            prod_reg;
    logic signed [15:0]     cos_reg, sin_reg;
    logic [23:0]            yprod_reg, uprod_reg, vprod_reg;
    logic [1:0]             k_reg, k_next;
    logic [1:0]             n_reg;
    logic [16:0]            px_reg, pz_reg;
    logic [15:0]            py_reg, nx_reg, ny_reg, nz_reg, u_reg, v_reg;
    logic [TRI_W-1:0]       tri0_reg, tri1_reg;

    logic [14:0]            cmag, smag;
    logic [30:0]            mc, ms;
    logic [16:0]            rc, rs, px_c, pz_c;
    logic [15:0]            py_c, nx_c, ny_c, nz_c, u_c, v_c, side_u;
    logic [TRI_W-1:0]       tri0_c, tri1_c;
    logic [1:0]             n_c;
    logic [INDEX_BITS-1:0]  oi, o1, ob, ob1, cci;
    logic [TRI_W-1:0]       tri_rec;
    logic                   is_tri;

    always_comb
    begin
        cmag = cos_reg[15] ? 15'(-cos_reg) : cos_reg[14:0];
        smag = sin_reg[15] ? 15'(-sin_reg) : sin_reg[14:0];
        mc = 31'(geom.radius) * 31'(cmag);
        ms = 31'(geom.radius) * 31'(smag);
        rc = 17'((mc + 31'd8192) >> 14);
        rs = 17'((ms + 31'd8192) >> 14);
        px_c = cos_reg[15] ? -rc : rc;
        pz_c = sin_reg[15] ? -rs : rs;

        oi = job_reg.o[INDEX_BITS-1:0];
        cci = job_reg.cc[INDEX_BITS-1:0];
        o1 = oi + INDEX_BITS'(1);
        ob = oi + INDEX_BITS'(job_reg.bseg);
        ob1 = ob + INDEX_BITS'(1);
        side_u = job_reg.jlast ? geom.u_tiling : uprod_reg[15:0];

        nx_c = '0;
        ny_c = '0;
        nz_c = '0;
        py_c = '0;
        u_c = '0;
        v_c = '0;
        tri0_c = '0;
        tri1_c = '0;
        n_c = 2'd1;
        if (job_reg.part == PART_SIDE)
        begin
            py_c = job_reg.ilast ? geom.height : yprod_reg[15:0];
            nx_c = cos_reg;
            nz_c = sin_reg;
            u_c = side_u;
            v_c = job_reg.ilast ? geom.v_tiling : vprod_reg[15:0];
            tri0_c = TRI_W'({ob, oi, ob1});
            tri1_c = TRI_W'({oi, o1, ob1});
            n_c = job_reg.ilast ? 2'd1 : 2'd3;
        end
        else if (job_reg.centre)
        begin
            py_c = (job_reg.part == PART_HIGH) ? geom.height : 16'd0;
            ny_c = (job_reg.part == PART_HIGH) ? 16'sd16384 : -16'sd16384;
            v_c = (job_reg.part == PART_HIGH) ? 16'd0 : geom.v_tiling;
        end
        else if (job_reg.part == PART_LOW)
        begin
            ny_c = -16'sd16384;
            u_c = job_reg.jlast ? 16'd256 : 16'((prod_reg + 24'd128) >> 8);
            tri0_c = TRI_W'({o1, oi, cci});
            n_c = job_reg.jlast ? 2'd1 : 2'd2;
        end
        else
        begin
            py_c = geom.height;
            ny_c = 16'sd16384;
            u_c = side_u;
            v_c = geom.v_tiling;
            tri0_c = TRI_W'({oi, o1, cci});
            n_c = job_reg.jlast ? 2'd1 : 2'd2;
        end

        job_ready = state_reg == B_IDLE;
        k_next = k_reg;
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (job_valid) state_next = B_PHASE;
            B_PHASE: state_next = B_TRIG;
            B_TRIG:  state_next = B_POS;
            B_POS:
            begin
                state_next = B_EMIT;
                k_next = '0;
            end
            B_EMIT:
            begin
                if (m_tready)
                begin
                    if (k_reg == n_reg - 2'd1)
                        state_next = B_IDLE;
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            default: state_next = B_IDLE;
        endcase

        is_tri = k_reg != 2'd0;
        tri_rec = (k_reg == 2'd1) ? tri0_reg : tri1_reg;
        m_tvalid = state_reg == B_EMIT;
        m_tlast = k_reg == n_reg - 2'd1;
        m_tuser = {job_reg.mesh_last, is_tri};
        if (is_tri)
            m_tdata = TDATA_W'({tri_rec, 130'd0});
        else
            m_tdata = TDATA_W'({51'd0, v_reg, u_reg, nz_reg, ny_reg, nx_reg,
                                 pz_reg, py_reg, px_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && job_valid)
            job_reg <= job;
        if (state_reg == B_PHASE)
            prod_reg <= 24'(job_reg.j) * 24'(job_reg.angle_step);
        if (state_reg == B_TRIG)
        begin
            cos_reg <= sin_at(prod_reg[15:0] + 16'h4000);
            sin_reg <= sin_at(prod_reg[15:0]);
            yprod_reg <= 24'(job_reg.i) * 24'(job_reg.h_step);
            uprod_reg <= 24'(job_reg.j) * 24'(job_reg.u_step);
            vprod_reg <= 24'(job_reg.i) * 24'(job_reg.v_step);
        end
        if (state_reg == B_POS)
        begin
            px_reg <= job_reg.centre ? 17'd0 : px_c;
            pz_reg <= job_reg.centre ? 17'd0 : pz_c;
            py_reg <= py_c;
            nx_reg <= nx_c;
            ny_reg <= ny_c;
            nz_reg <= nz_c;
            u_reg <= u_c;
            v_reg <= v_c;
            tri0_reg <= tri0_c;
            tri1_reg <= tri1_c;
            n_reg <= n_c;
        end
    end

endmodule
`default_nettype wire

// ----- src/cylinder_mesh_generator.sv -----
`default_nettype none
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-----------------------------------------
// input    | s_tvalid / s_tready         | s_tdata[0] restart
// result   | m_tvalid / m_tready         | m_tdata vertex or triangle, m_tuser, m_tlast
// config   | cfg_valid / cfg_ready       | cfg_index register, cfg_data value
//
// An advance item passes through the queue, then through the back part's steps
// (taking the job, phase multiply, table lookup, radius multiply) and delivers its
// results one per cycle while m_tready is high; the front queues up to four vertices so
// it keeps taking items while results wait, until the queue is full. A restart item
// rewinds the walk and runs four divisions on the shared divider, during which s_tready
// is low. Reset leaves the walk finished, so advances give nothing until the first
// restart. Configuration writes are always taken.
module cylinder_mesh_generator #(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int MAX_SEGMENTS = 255,
    parameter int INDEX_BITS = 17
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [16:0] pos_x, [32:17] pos_y, [49:33] pos_z, [65:50] norm_x, [81:66] norm_y,
    // [97:82] norm_z, [113:98] tex_u, [129:114] tex_v, [180:130] tri_indices
    output logic [cmg_pkg::TDATA_W-1:0]         m_tdata,
    output logic [cmg_pkg::TUSER_W-1:0]         m_tuser,   // [0] kind, [1] mesh_end
    output logic                                m_tlast,   // run_last
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [2:0]                     cfg_index,
    input  wire logic [15:0]                    cfg_data
);
    import cmg_pkg::*;

    logic [15:0]    radius_reg, height_reg, u_tiling_reg, v_tiling_reg;
    logic [7:0]     bseg_reg, hseg_reg;
    logic           caps_reg;
    logic           push_valid, push_ready, pop_valid, pop_ready;
    job_t           push_job, pop_job;
    geom_cfg_t      geom;

    assign cfg_ready = 1'b1;

    // Configuration registers; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            height_reg <= 16'd256;
            bseg_reg <= 8'd16;
            hseg_reg <= 8'd1;
            caps_reg <= 1'b1;
            u_tiling_reg <= 16'd256;
            v_tiling_reg <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS:          radius_reg <= cfg_data;
                REG_HEIGHT:          height_reg <= cfg_data;
                REG_BASE_SEGMENTS:   bseg_reg <= cfg_data[7:0];
                REG_HEIGHT_SEGMENTS: hseg_reg <= cfg_data[7:0];
                REG_WITH_CAPS:       caps_reg <= cfg_data[0];
                REG_U_TILING:        u_tiling_reg <= cfg_data;
                REG_V_TILING:        v_tiling_reg <= cfg_data;
                default:             caps_reg <= caps_reg;
            endcase
        end
    end

    // The back part reads geometry registers live; the user must change them only when idle; not enforced.
    always_comb
    begin
        geom.radius = radius_reg;
        geom.height = height_reg;
        geom.u_tiling = u_tiling_reg;
        geom.v_tiling = v_tiling_reg;
    end

    // Front part: walks the mesh and turns each advance into a vertex job until the walk is finished.
    cmg_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .restart         (s_tdata[0]),
        .base_segments   (bseg_reg),
        .height_segments (hseg_reg),
        .with_caps       (caps_reg),
        .height          (height_reg),
        .u_tiling        (u_tiling_reg),
        .v_tiling        (v_tiling_reg),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_job        (push_job)
    );

    cmg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back part: builds the vertex and its triangles and delivers them in order.
    cmg_back #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .INDEX_BITS       (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .geom      (geom),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire
